// File: hw/rtl/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
// No dependencies; compiled first.
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 5;
	localparam int DATA_W = 32;

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	// per-cell control from the queue controller
	typedef struct packed {
		logic upd;     // add item accepted this cycle
		logic occ;     // cell holds a value
		logic at_tail; // first free cell
	} cell_ctl_t;

endpackage

// File: hw/rtl/spq_if.sv
// Item channel interfaces for the sorted priority queue.
// Depends on spq_pkg.
interface spq_req_if;
	import spq_pkg::*;
	logic  valid;
	logic  ready;
	logic  kind;
	data_t value;

	modport source (output valid, kind, value, input ready);
	modport sink   (input valid, kind, value, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	data_t              removed_value;
	data_t              min_value;
	logic [CNT_W-1:0]   entry_count;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, status, removed_value, min_value, entry_count,
		is_empty, is_full, input ready);
	modport sink   (input valid, status, removed_value, min_value, entry_count,
		is_empty, is_full, output ready);
endinterface

// File: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds a value, compares it with the new item
// and takes either its lower neighbor's value or the new value. Uses spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::data_t     value,
	input  logic               prev_move,
	input  spq_pkg::data_t     prev_val,
	output logic               move,
	output spq_pkg::data_t     val_q,
	output spq_pkg::data_t     val_nxt
);
	import spq_pkg::*;

	// value belongs below this cell: this cell moves up one slot
	assign move = ctl.occ && (value < val_q);

	always_comb begin
		val_nxt = val_q;
		if (ctl.upd) begin
			if (prev_move) begin
				val_nxt = prev_val;
			end else if (move || ctl.at_tail) begin
				val_nxt = value;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue top level: chain of spq_cell slots, count and output
// register. Depends on spq_pkg, spq_if.sv and spq_cell.
//
//  channel  dir   payload                                    handshake
//  req      sink  kind, value                                valid/ready
//  rsp      src   status, removed_value, min_value,          valid/ready
//                 entry_count, is_empty, is_full
//  cfg      sink  capacity_limit (cfg_wdata)                 cfg_we
//
// One item per cycle while no result is held by a low rsp.ready: all cells compare
// against the new value at once and shift in the same edge that registers the result.
// req.ready is low only while a result waits and rsp.ready is low.
// arst_n clears count, capacity (to 16) and the result valid flag.
module sorted_priority_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	spq_req_if.sink               req,
	spq_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [spq_pkg::CNT_W-1:0] cfg_wdata
);
	import spq_pkg::*;

	cnt_t       cap_q;
	cnt_t       count_q;
	cnt_t       count_nxt;
	cnt_t       eff_cap;
	logic       rsp_valid_q;
	logic       acc;
	logic       add_ok;
	logic       rem_ok;
	status_t    status;
	data_t      removed;
	data_t      cell_q   [DEPTH];
	data_t      cell_nxt [DEPTH];
	logic [DEPTH-1:0] move;
	cell_ctl_t  ctl      [DEPTH];
	logic [IDX_W-1:0] top_idx;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	always_comb begin
		eff_cap = cap_q;
		if (cap_q == '0) eff_cap = cnt_t'(1);
		if (cap_q > cnt_t'(DEPTH)) eff_cap = cnt_t'(DEPTH);
	end

	always_comb begin
		add_ok    = 1'b0;
		rem_ok    = 1'b0;
		status    = ST_DONE;
		count_nxt = count_q;
		if (req.kind == KIND_ADD) begin
			if (count_q >= eff_cap) begin
				status = ST_FULL;
			end else begin
				add_ok    = acc;
				count_nxt = count_q + cnt_t'(1);
			end
		end else begin
			if (count_q == '0) begin
				status = ST_EMPTY;
			end else begin
				rem_ok    = acc;
				count_nxt = count_q - cnt_t'(1);
			end
		end
	end

	assign top_idx = IDX_W'(count_q - cnt_t'(1));
	assign removed = (req.kind == KIND_REMOVE && count_q != '0) ? cell_q[top_idx] : '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl[i].upd     = add_ok;
		assign ctl[i].occ     = cnt_t'(i) < count_q;
		assign ctl[i].at_tail = cnt_t'(i) == count_q;

		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl[i]),
				.value     (req.value),
				.prev_move (1'b0),
				.prev_val  (req.value),
				.move      (move[i]),
				.val_q     (cell_q[i]),
				.val_nxt   (cell_nxt[i])
			);
		end else begin : g_body
			spq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl[i]),
				.value     (req.value),
				.prev_move (move[i-1]),
				.prev_val  (cell_q[i-1]),
				.move      (move[i]),
				.val_q     (cell_q[i]),
				.val_nxt   (cell_nxt[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= cnt_t'(DEPTH);
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (add_ok || rem_ok) count_q <= count_nxt;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			rsp.status        <= status;
			rsp.removed_value <= removed;
			rsp.min_value     <= (count_nxt != '0) ? cell_nxt[0] : '0;
			rsp.entry_count   <= count_nxt;
			rsp.is_empty      <= count_nxt == '0;
			rsp.is_full       <= count_nxt >= eff_cap;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule
